// ----- hdl/tfir_pkg.sv -----
// package for the transposed fir filter: constants, command and state types
package tfir_pkg;

    localparam int MAX_ORDER_DEF = 15;

    localparam int DATA_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int ORDER_W = 4;
    localparam int CMD_W   = 2;
    localparam int STATE_W = 40;
    localparam int PROD_W  = 32;
    localparam int GPROD_W = 49;
    localparam int TAP_W   = 37;
    localparam int SUM_W   = 41;
    localparam int Y_W     = 26;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd4096;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd15;

    // configuration register indexes
    localparam logic REG_GAIN  = 1'b0;
    localparam logic REG_ORDER = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_FILL   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } fsm_t;

endpackage

// ----- hdl/transposed_fir_filter_unit.sv -----
// transposed-form fir filter with gain, coefficients and delay line in memories
//
// input channel: in_valid/in_ready carry one word of command, sample, tap_index,
// coefficient and state_fill. command 0 filters a sample and gives one output
// word, command 1 loads one coefficient, command 2 fills the whole delay line,
// command 3 does nothing. loads and fills are done at acceptance.
// a sample walks the taps through one multiply chain, one memory entry per cycle:
// order + 1 reads pass three pipeline stages, a drain state waits to see the pipe
// empty and a done state loads the output register, where out_valid rises; only
// then is the next word taken, so no word is taken while a sample is in flight.
// a finished result waits in the output register, so the receiver stalling only
// holds back the completion of the sample after it, and with it the input.
// configuration: cfg_write with cfg_index 0 (gain) or 1 (order) and
// cfg_data, to be written only while idle; the block itself does not enforce it.
// reset: gain 1.0, order 15, all coefficients and delay entries read as zero;
// the memories are not swept, per-entry valid flops stand in for the clear.
module transposed_fir_filter_unit
    import tfir_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [GAIN_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           command,
    input  logic signed [DATA_W-1:0]   sample,
    input  logic [ORDER_W-1:0]         tap_index,
    input  logic signed [DATA_W-1:0]   coefficient,
    input  logic signed [DATA_W-1:0]   state_fill,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DATA_W-1:0]   filtered_sample,
    output logic                       saturated
);

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    // configuration
    logic [GAIN_W-1:0]  gain_reg;
    logic [ORDER_W-1:0] order_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            order_cfg_reg <= ORDER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN:  gain_reg      <= cfg_data;
                REG_ORDER: order_cfg_reg <= cfg_data[ORDER_W-1:0];
                default:   gain_reg      <= gain_reg;
            endcase
        end
    end

    // control
    fsm_t state_reg, state_next;
    logic issue_en;
    logic out_load;
    logic in_fire;

    logic [AW-1:0] issue_reg;
    logic [AW-1:0] order_reg;
    logic [AW-1:0] order_eff;

    logic p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [AW-1:0] p1_idx_reg, p2_idx_reg, p3_idx_reg;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        if (32'(order_cfg_reg) > MAX_ORDER)
            order_eff = AW'(MAX_ORDER);
        else
            order_eff = AW'(order_cfg_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (command == CMD_SAMPLE))
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (issue_reg == order_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!p1_vld_reg && !p2_vld_reg && !p3_vld_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        issue_en = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_RUN:   issue_en = 1'b1;
            ST_DRAIN: issue_en = 1'b0;
            ST_DONE:  out_load = !out_valid || out_ready;
            default:  in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sample and order latched at acceptance
    logic signed [DATA_W-1:0] x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= '0;
            order_reg <= '0;
        end
        else if (in_fire && (command == CMD_SAMPLE))
        begin
            issue_reg <= '0;
            order_reg <= order_eff;
        end
        else if (issue_en)
        begin
            issue_reg <= issue_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (command == CMD_SAMPLE))
            x_reg <= sample;
    end

    // coefficient memory, entries read as zero until loaded
    logic signed [DATA_W-1:0] coef_mem [DEPTH];
    logic [DEPTH-1:0]         coef_vld_reg;
    logic                     load_en;
    logic [AW-1:0]            load_addr;

    assign load_en   = in_fire && (command == CMD_LOAD) && (32'(tap_index) <= MAX_ORDER);
    assign load_addr = AW'(tap_index);

    always_ff @(posedge clk)
    begin
        if (load_en)
            coef_mem[load_addr] <= coefficient;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_vld_reg <= '0;
        else if (load_en)
            coef_vld_reg[load_addr] <= 1'b1;
    end

    // delay line memory; an entry not written since the last fill reads the fill value
    logic signed [STATE_W-1:0] state_mem [DEPTH];
    logic [DEPTH-1:0]          state_vld_reg;
    logic signed [DATA_W-1:0]  fill_reg;
    logic                      fill_en;
    logic                      st_wr_en;
    logic [AW-1:0]             st_wr_addr;
    logic signed [STATE_W-1:0] st_wr_data;

    assign fill_en = in_fire && (command == CMD_FILL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            state_vld_reg <= '0;
        end
        else if (fill_en)
        begin
            fill_reg      <= state_fill;
            state_vld_reg <= '0;
        end
        else if (st_wr_en)
        begin
            state_vld_reg[st_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_wr_en)
            state_mem[st_wr_addr] <= st_wr_data;
    end

    // read stage: entry k feeds the output (k = 0) or the new s[k-1]
    logic signed [DATA_W-1:0]  coef_rd_reg;
    logic signed [STATE_W-1:0] state_rd_reg;
    logic                      coef_ok_reg;
    logic                      state_ok_reg;

    always_ff @(posedge clk)
    begin
        if (issue_en)
        begin
            coef_rd_reg  <= coef_mem[issue_reg];
            state_rd_reg <= state_mem[issue_reg];
            coef_ok_reg  <= coef_vld_reg[issue_reg];
            state_ok_reg <= state_vld_reg[issue_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= issue_en;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    // multiply stages: b*x, then times gain
    logic signed [DATA_W-1:0]  b_sel;
    logic signed [STATE_W-1:0] s_sel;
    logic signed [PROD_W-1:0]  prod1_reg;
    logic signed [GPROD_W-1:0] prod2_reg;
    logic signed [STATE_W-1:0] s2_reg, s3_reg;

    assign b_sel = coef_ok_reg ? coef_rd_reg : '0;
    assign s_sel = state_ok_reg ? state_rd_reg
                                : {{(STATE_W-DATA_W-15){fill_reg[DATA_W-1]}}, fill_reg, 15'd0};

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= issue_reg;
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        prod1_reg  <= b_sel * x_reg;
        s2_reg     <= s_sel;
        prod2_reg  <= prod1_reg * $signed({1'b0, gain_reg});
        s3_reg     <= s2_reg;
    end

    // round, accumulate, saturate
    logic signed [GPROD_W-1:0] rnd;
    logic signed [TAP_W-1:0]   tap;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   ysum;
    logic signed [Y_W-1:0]     yfull;
    logic signed [DATA_W-1:0]  y_sat;
    logic                      y_clip;
    logic                      s_clip;

    assign rnd  = prod2_reg + GPROD_W'(2048);
    assign tap  = rnd[GPROD_W-1:12];
    assign sum  = {{(SUM_W-TAP_W){tap[TAP_W-1]}}, tap} + {s3_reg[STATE_W-1], s3_reg};
    assign ysum = sum + SUM_W'(16384);
    assign yfull = ysum[SUM_W-1:15];

    always_comb
    begin
        y_clip = 1'b0;
        y_sat  = yfull[DATA_W-1:0];
        if (yfull > Y_W'(32767))
        begin
            y_sat  = 16'sh7fff;
            y_clip = 1'b1;
        end
        else if (yfull < -Y_W'(32768))
        begin
            y_sat  = 16'sh8000;
            y_clip = 1'b1;
        end
    end

    always_comb
    begin
        s_clip     = sum[SUM_W-1] != sum[SUM_W-2];
        st_wr_data = sum[STATE_W-1:0];
        if (s_clip)
            st_wr_data = sum[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                      : {1'b0, {(STATE_W-1){1'b1}}};
    end

    assign st_wr_en   = p3_vld_reg && (p3_idx_reg != '0);
    assign st_wr_addr = p3_idx_reg - 1'b1;

    // pending result and clip flag of the sample in flight
    logic signed [DATA_W-1:0] y_hold_reg;
    logic                     clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clip_reg <= 1'b0;
        else if (in_fire && (command == CMD_SAMPLE))
            clip_reg <= 1'b0;
        else if (p3_vld_reg)
            clip_reg <= clip_reg | ((p3_idx_reg == '0) ? y_clip : s_clip);
    end

    always_ff @(posedge clk)
    begin
        if (p3_vld_reg && (p3_idx_reg == '0))
            y_hold_reg <= y_sat;
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            filtered_sample <= y_hold_reg;
            saturated       <= clip_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
